/* rtl/core/rc4ksc_pkg.sv */
// Package with shared constants, a type and a helper function of the RC4 keystream cipher.
`default_nettype none

package rc4ksc_pkg;

  // Permutation store geometry.
  localparam int PERM_DEPTH  = 256;
  localparam int PERM_ADDR_W = $clog2(PERM_DEPTH);
  localparam int BYTE_W      = 8;

  // Key storage.
  localparam int MAX_KEY_BYTES = 16;
  localparam int KEY_WORD_W    = 64;
  localparam int KEY_LEN_W     = 5;
  localparam int KEY_IDX_W     = 4;
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'd8;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = KEY_WORD_W;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 2'd2;

  // One request to the permutation memory: one write and one read per cycle.
  typedef struct packed {
    logic                   we;
    logic [PERM_ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0]      wdata;
    logic                   re;
    logic [PERM_ADDR_W-1:0] raddr;
  } ram_req_t;

  // Index of the last key byte used: the length is clamped to 1..MAX_KEY_BYTES.
  function automatic logic [KEY_IDX_W-1:0] last_key_idx(input logic [KEY_LEN_W-1:0] len);
    logic [KEY_LEN_W-1:0] eff;
    begin
      eff = len;
      if (eff == '0) begin
        eff = KEY_LEN_W'(1);
      end
      if (eff > KEY_LEN_W'(MAX_KEY_BYTES)) begin
        eff = KEY_LEN_W'(MAX_KEY_BYTES);
      end
      return KEY_IDX_W'(eff - KEY_LEN_W'(1));
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/core/rc4ksc_in_if.sv */
// Interface of the input channel: data byte and end-of-message flag.
`default_nettype none

interface rc4ksc_in_if;
  logic                        valid;
  logic                        ready;
  logic [rc4ksc_pkg::BYTE_W-1:0] data_byte;
  logic                        last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

/* rtl/core/rc4ksc_out_if.sv */
// Interface of the output channel: combined byte and end-of-message flag.
`default_nettype none

interface rc4ksc_out_if;
  logic                        valid;
  logic                        ready;
  logic [rc4ksc_pkg::BYTE_W-1:0] cipher_byte;
  logic                        last_out;

  modport source (output valid, output cipher_byte, output last_out, input ready);
  modport sink   (input valid, input cipher_byte, input last_out, output ready);
endinterface

`default_nettype wire

/* rtl/core/rc4ksc_perm_ram.sv */
// Permutation memory: 256 bytes, one write port and one registered read port.
`default_nettype none

module rc4ksc_perm_ram (
  input  wire logic                              clk,
  input  wire rc4ksc_pkg::ram_req_t              req,
  output logic [rc4ksc_pkg::BYTE_W-1:0]          rd_data
);

  logic [rc4ksc_pkg::BYTE_W-1:0] mem [rc4ksc_pkg::PERM_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // A read in the same cycle as a write to the same entry returns the old value.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/rc4_keystream_cipher_top.sv */
// Top level of the RC4 keystream cipher: control sequencer, key registers and output stage.
//
//   Channel   Direction  Payload                    Transaction when
//   din       in         data_byte[7:0], last_byte  din.valid && din.ready
//   dout      out        cipher_byte[7:0], last_out dout.valid && dout.ready
//   cfg       in         cfg_index[1:0], cfg_data   cfg_we high at the clock edge
//
// A byte within a message goes through these steps: accept it and issue the read of S[i],
// then the read of S[j], the first write of the swap with the keystream read, and the
// second write. The single write port of the memory splits the swap into two writes. The
// first byte after reset or after a last byte first runs the key schedule: an identity
// fill of S, then for each of the 256 mixing steps a read of S[n], a read of S[j] and the
// two swap writes. rst is synchronous and active high; it clears the control state and
// the key registers but not the memory, which the schedule always fills before use. The
// output register frees the input side: a new byte is taken while a result still waits,
// and the sequencer only holds in its last step when the output register is still full.
`default_nettype none

module rc4_keystream_cipher_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  rc4ksc_in_if.sink                                din,
  rc4ksc_out_if.source                             dout,
  input  wire logic                                cfg_we,
  input  wire logic [rc4ksc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rc4ksc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW = rc4ksc_pkg::PERM_ADDR_W;
  localparam int BW = rc4ksc_pkg::BYTE_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_KS_RD_I,
    ST_KS_RD_J,
    ST_KS_WR_I,
    ST_KS_WR_J,
    ST_PR_RD_I,
    ST_PR_RD_J,
    ST_PR_WR_I,
    ST_PR_WR_J
  } state_t;

  // Configuration registers.
  logic [rc4ksc_pkg::KEY_WORD_W-1:0] key_low;
  logic [rc4ksc_pkg::KEY_WORD_W-1:0] key_high;
  logic [rc4ksc_pkg::KEY_LEN_W-1:0]  key_length;

  // Sequencer state.
  state_t                             state;
  logic [AW-1:0]                      ctr;
  logic [AW-1:0]                      index_i;
  logic [AW-1:0]                      index_j;
  logic                               needs_schedule;
  logic [rc4ksc_pkg::KEY_IDX_W-1:0]   key_idx;
  logic [BW-1:0]                      si;
  logic [BW-1:0]                      sj;
  logic [AW-1:0]                      t_addr;
  logic [BW-1:0]                      data_r;
  logic                               last_r;

  // Output stage.
  logic                               out_valid;
  logic [BW-1:0]                      out_byte;
  logic                               out_last;

  rc4ksc_pkg::ram_req_t               ram_req;
  logic [BW-1:0]                      rd_data;

  logic [2*rc4ksc_pkg::KEY_WORD_W-1:0] key_bytes;
  logic [BW-1:0]                      key_b;
  logic [AW-1:0]                      j_ks;
  logic [AW-1:0]                      j_pr;
  logic [AW-1:0]                      t_sum;
  logic [BW-1:0]                      ks;
  logic                               in_acc;
  logic                               out_free;
  logic                               last_ctr;
  logic                               last_key;

  assign key_bytes = {key_high, key_low};
  assign key_b     = key_bytes[key_idx*BW +: BW];
  assign last_key  = (key_idx == rc4ksc_pkg::last_key_idx(key_length));
  assign last_ctr  = (ctr == AW'(rc4ksc_pkg::PERM_DEPTH - 1));

  // Key schedule step: j += S[n] + key byte. Keystream step: j += S[i].
  assign j_ks  = index_j + rd_data + key_b;
  assign j_pr  = index_j + rd_data;
  // After the swap S[i] holds the old S[j] and S[j] the old S[i]; their sum is unchanged.
  assign t_sum = si + rd_data;

  // The read of S[t] was issued before S[j] was written, so entries i and j are forwarded.
  always_comb begin
    if (t_addr == index_j) begin
      ks = si;
    end else if (t_addr == index_i) begin
      ks = sj;
    end else begin
      ks = rd_data;
    end
  end

  assign din.ready   = (state == ST_IDLE);
  assign in_acc      = din.valid && din.ready;
  assign out_free    = !out_valid || dout.ready;

  assign dout.valid       = out_valid;
  assign dout.cipher_byte = out_byte;
  assign dout.last_out    = out_last;

  // Memory requests of each step.
  always_comb begin
    ram_req = '0;
    unique case (state)
      ST_IDLE: begin
        ram_req.re    = in_acc && !needs_schedule;
        ram_req.raddr = index_i + AW'(1);
      end
      ST_INIT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = ctr;
        ram_req.wdata = BW'(ctr);
      end
      ST_KS_RD_I: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = ctr;
      end
      ST_KS_RD_J: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = j_ks;
      end
      ST_KS_WR_I: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = ctr;
        ram_req.wdata = rd_data;
      end
      ST_KS_WR_J: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = index_j;
        ram_req.wdata = si;
      end
      ST_PR_RD_I: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = index_i + AW'(1);
      end
      ST_PR_RD_J: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = j_pr;
      end
      ST_PR_WR_I: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = index_i;
        ram_req.wdata = rd_data;
        ram_req.re    = 1'b1;
        ram_req.raddr = t_sum;
      end
      ST_PR_WR_J: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = index_j;
        ram_req.wdata = si;
      end
      default: begin
        ram_req = '0;
      end
    endcase
  end

  rc4ksc_perm_ram u_perm_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  // Configuration writes; an index beyond the register list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low    <= '0;
      key_high   <= '0;
      key_length <= rc4ksc_pkg::KEY_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rc4ksc_pkg::CFG_KEY_LOW:    key_low    <= cfg_data;
        rc4ksc_pkg::CFG_KEY_HIGH:   key_high   <= cfg_data;
        rc4ksc_pkg::CFG_KEY_LENGTH: key_length <= cfg_data[rc4ksc_pkg::KEY_LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      index_i        <= '0;
      index_j        <= '0;
      needs_schedule <= 1'b1;
      out_valid      <= 1'b0;
    end else begin
      // In the last step the output register is either loaded or still held full.
      if (dout.ready && state != ST_PR_WR_J) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            data_r <= din.data_byte;
            last_r <= din.last_byte;
            if (needs_schedule) begin
              ctr   <= '0;
              state <= ST_INIT;
            end else begin
              index_i <= index_i + AW'(1);
              state   <= ST_PR_RD_J;
            end
          end
        end
        ST_INIT: begin
          if (last_ctr) begin
            ctr     <= '0;
            index_j <= '0;
            key_idx <= '0;
            state   <= ST_KS_RD_I;
          end else begin
            ctr <= ctr + AW'(1);
          end
        end
        ST_KS_RD_I: begin
          state <= ST_KS_RD_J;
        end
        ST_KS_RD_J: begin
          si      <= rd_data;
          index_j <= j_ks;
          state   <= ST_KS_WR_I;
        end
        ST_KS_WR_I: begin
          state <= ST_KS_WR_J;
        end
        ST_KS_WR_J: begin
          key_idx <= last_key ? '0 : key_idx + rc4ksc_pkg::KEY_IDX_W'(1);
          if (last_ctr) begin
            index_i        <= '0;
            index_j        <= '0;
            needs_schedule <= 1'b0;
            state          <= ST_PR_RD_I;
          end else begin
            ctr   <= ctr + AW'(1);
            state <= ST_KS_RD_I;
          end
        end
        ST_PR_RD_I: begin
          index_i <= index_i + AW'(1);
          state   <= ST_PR_RD_J;
        end
        ST_PR_RD_J: begin
          si      <= rd_data;
          index_j <= j_pr;
          state   <= ST_PR_WR_I;
        end
        ST_PR_WR_I: begin
          sj     <= rd_data;
          t_addr <= t_sum;
          state  <= ST_PR_WR_J;
        end
        ST_PR_WR_J: begin
          // The second write repeats harmlessly while the output register is still full.
          if (out_free) begin
            out_valid <= 1'b1;
            out_byte  <= data_r ^ ks;
            out_last  <= last_r;
            if (last_r) begin
              needs_schedule <= 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/rc4ksc_checker.sv */
// Port-level checker of the RC4 keystream cipher and its binding to the top level.
`default_nettype none

module rc4ksc_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [rc4ksc_pkg::BYTE_W-1:0] out_cipher_byte,
  input wire logic                          out_last
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Transactions taken in but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_acc && !out_acc) begin
      pending <= pending + 2'd1;
    end else if (out_acc && !in_acc) begin
      pending <= pending - 2'd1;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst) in_acc |=> !in_ready)
    else $error("input taken while a byte is still in work");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst) pending != 2'd3)
    else $error("more than two transactions outstanding");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
      (pending == 2'd0) |-> !out_valid)
    else $error("result without a matching input transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
      out_valid && !out_ready |=> out_valid && $stable(out_cipher_byte) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind rc4_keystream_cipher_top rc4ksc_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (din.valid),
  .in_ready        (din.ready),
  .out_valid       (dout.valid),
  .out_ready       (dout.ready),
  .out_cipher_byte (dout.cipher_byte),
  .out_last        (dout.last_out)
);

`default_nettype wire

/* tb/tb.sv */
// Testbench of the RC4 keystream cipher: directed and random messages checked against a predictor.
`timescale 1ns / 100ps

module tb;

  // Index with no register behind it: writes to it must leave the key untouched.
  localparam logic [rc4ksc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  localparam int unsigned RANDOM_ITEMS  = 1330;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned LIMIT_CYCLES  = 2_000_000;

  typedef struct packed {
    logic [rc4ksc_pkg::BYTE_W-1:0] cipher_byte;
    logic                          last_out;
  } cipher_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                              cfg_we    = 1'b0;
  logic [rc4ksc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rc4ksc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  rc4ksc_in_if  din_if ();
  rc4ksc_out_if dout_if ();

  rc4_keystream_cipher_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .din       (din_if),
    .dout      (dout_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // The testbench's own copy of the cipher state and of the key registers.
  logic [rc4ksc_pkg::KEY_WORD_W-1:0] key_lo_m  = '0;
  logic [rc4ksc_pkg::KEY_WORD_W-1:0] key_hi_m  = '0;
  logic [rc4ksc_pkg::KEY_LEN_W-1:0]  key_len_m = rc4ksc_pkg::KEY_LEN_RESET;
  logic [rc4ksc_pkg::BYTE_W-1:0]     perm_m [rc4ksc_pkg::PERM_DEPTH];
  logic [rc4ksc_pkg::BYTE_W-1:0]     idx_i_m = '0;
  logic [rc4ksc_pkg::BYTE_W-1:0]     idx_j_m = '0;
  bit                                sched_due = 1'b1;

  // Results still owed by the block, oldest first.
  cipher_res_t cipher_due [$];

  int unsigned items_sent  = 0;
  int unsigned items_back  = 0;
  int unsigned sched_count = 0;
  int unsigned cfg_writes  = 0;
  int unsigned errors      = 0;
  int unsigned cycle_count = 0;

  // Sender and receiver idling modes; a burst mode removes every gap.
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;
  logic        rx_ready = 1'b0;
  int unsigned rx_wait  = 0;
  bit          rx_hold  = 1'b0;
  int unsigned stall_cycles = 0;
  event        rx_hold_go;

  assign dout_if.ready = rx_ready;

  // Predicts one result. The key schedule runs on the first byte of a message and uses the
  // key registers as they stand at that moment, so a key written mid-message only shows up
  // in the next message. Lengths of zero are read as one and lengths above the maximum are
  // saturated.
  function automatic cipher_res_t rc4_encipher(input logic [rc4ksc_pkg::BYTE_W-1:0] data,
                                               input logic last);
    cipher_res_t res;
    int unsigned n, len, k;
    logic [rc4ksc_pkg::BYTE_W-1:0] acc, tmp, kb, ks_idx;
    logic [rc4ksc_pkg::KEY_WORD_W-1:0] word;
    if (sched_due) begin
      len = 32'(key_len_m);
      if (len == 0) begin
        len = 1;
      end
      if (len > rc4ksc_pkg::MAX_KEY_BYTES) begin
        len = rc4ksc_pkg::MAX_KEY_BYTES;
      end
      for (n = 0; n < rc4ksc_pkg::PERM_DEPTH; n++) begin
        perm_m[n] = 8'(n);
      end
      acc = '0;
      for (n = 0; n < rc4ksc_pkg::PERM_DEPTH; n++) begin
        k = (n % len) & 15;
        word = (k < 8) ? key_lo_m : key_hi_m;
        kb = word[(k % 8) * 8 +: 8];
        acc = acc + perm_m[n] + kb;
        tmp = perm_m[n];
        perm_m[n] = perm_m[acc];
        perm_m[acc] = tmp;
      end
      idx_i_m = '0;
      idx_j_m = '0;
      sched_due = 1'b0;
      sched_count++;
    end
    idx_i_m = idx_i_m + 8'd1;
    idx_j_m = idx_j_m + perm_m[idx_i_m];
    tmp = perm_m[idx_i_m];
    perm_m[idx_i_m] = perm_m[idx_j_m];
    perm_m[idx_j_m] = tmp;
    ks_idx = perm_m[idx_i_m] + perm_m[idx_j_m];
    res.cipher_byte = data ^ perm_m[ks_idx];
    res.last_out = last;
    if (last) begin
      sched_due = 1'b1;
    end
    return res;
  endfunction

  function automatic logic [rc4ksc_pkg::KEY_WORD_W-1:0] rand_key_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Offers one byte after a random gap and returns at the edge where the transaction
  // happens. Valid is only lowered when a gap follows, so back-to-back bytes never see
  // valid lowered and raised in the same time step.
  task automatic send_byte(input logic [rc4ksc_pkg::BYTE_W-1:0] data, input logic last);
    int unsigned gap;
    cipher_res_t exp_res;
    gap = tx_burst ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      din_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din_if.valid     <= 1'b1;
    din_if.data_byte <= data;
    din_if.last_byte <= last;
    exp_res = rc4_encipher(data, last);
    cipher_due = {cipher_due, exp_res};
    do @(posedge clk); while (!din_if.ready);
    items_sent++;
  endtask

  // Stops offering and waits until every owed result has come back, then waits out the settle time.
  task automatic settle();
    din_if.valid <= 1'b0;
    while (cipher_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only with the block idle; the predictor follows each write.
  task automatic cfg_write(input logic [rc4ksc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rc4ksc_pkg::CFG_DATA_W-1:0] data);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rc4ksc_pkg::CFG_KEY_LOW:    key_lo_m  = data;
      rc4ksc_pkg::CFG_KEY_HIGH:   key_hi_m  = data;
      rc4ksc_pkg::CFG_KEY_LENGTH: key_len_m = data[rc4ksc_pkg::KEY_LEN_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Receiver: after each transaction it may lower ready for a random wait, and now and then it
  // switches between idling and burst mode. A hold request keeps ready low throughout.
  always @(posedge clk) begin
    int unsigned draw;
    if (rst) begin
      rx_ready <= 1'b0;
      rx_wait  <= 0;
    end else if (rx_hold) begin
      rx_ready <= 1'b0;
      rx_wait  <= 0;
    end else if (rx_ready) begin
      if (dout_if.valid) begin
        if ($urandom_range(0, 39) == 0) begin
          rx_burst <= !rx_burst;
        end
        draw = rx_burst ? 0 : $urandom_range(0, 14);
        if (draw != 0) begin
          rx_wait  <= draw - 1;
          rx_ready <= 1'b0;
        end
      end
    end else if (rx_wait == 0) begin
      rx_ready <= 1'b1;
    end else begin
      rx_wait <= rx_wait - 1;
    end
  end

  // A long hold-off of the receiver, counted here so that the sender can go on offering bytes
  // and the block fills up until its input stalls.
  initial begin : rx_hold_proc
    forever begin
      @(rx_hold_go);
      rx_hold <= 1'b1;
      repeat (stall_cycles) @(posedge clk);
      rx_hold <= 1'b0;
    end
  end

  // Every result transaction is compared, field by field, with the oldest expectation.
  always @(posedge clk) begin
    cipher_res_t got, want;
    if (!rst && dout_if.valid && dout_if.ready) begin
      got.cipher_byte = dout_if.cipher_byte;
      got.last_out    = dout_if.last_out;
      items_back++;
      if (cipher_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual cipher_byte %02h last_out %0b",
                 $time, got.cipher_byte, got.last_out);
      end else begin
        want = cipher_due.pop_front();
        if (got.cipher_byte !== want.cipher_byte) begin
          errors++;
          $display("%0t: cipher_byte mismatch, expected %02h, actual %02h",
                   $time, want.cipher_byte, got.cipher_byte);
        end
        if (got.last_out !== want.last_out) begin
          errors++;
          $display("%0t: last_out mismatch, expected %0b, actual %0b",
                   $time, want.last_out, got.last_out);
        end
      end
    end
  end

  // Watchdog: a run that hangs ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("tb failed");
      $finish;
    end
  end

  // The reset key (all zero, eight bytes) with the extremes of the data byte.
  task automatic test_default_key();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h3C, 1'b1);
  endtask

  // Key lengths at both ends of the range, plus zero and values above the maximum, which
  // the block must treat as one and as the maximum respectively.
  task automatic test_key_lengths();
    logic [rc4ksc_pkg::KEY_LEN_W-1:0] lens [5];
    int t;
    lens = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17};
    cfg_write(rc4ksc_pkg::CFG_KEY_LOW, 64'h0123_4567_89AB_CDEF);
    cfg_write(rc4ksc_pkg::CFG_KEY_HIGH, '1);
    for (t = 0; t < 5; t++) begin
      if (t == 1) begin
        cfg_write(rc4ksc_pkg::CFG_KEY_LOW, '1);
      end else if (t == 2) begin
        cfg_write(rc4ksc_pkg::CFG_KEY_HIGH, 64'hFEDC_BA98_7654_3210);
      end
      cfg_write(rc4ksc_pkg::CFG_KEY_LENGTH, rc4ksc_pkg::CFG_DATA_W'(lens[t]));
      if (t < 2) begin
        send_byte(8'hFF, 1'b0);
      end
      send_byte(8'h00, 1'b1);
    end
  endtask

  // A write to the index beyond the register list must change nothing.
  task automatic test_ignored_index();
    cfg_write(CFG_UNUSED_IDX, '1);
    send_byte(8'h81, 1'b1);
  endtask

  // Key and length written in the middle of a message: the running message keeps its
  // keystream and the new key only takes over with the next message.
  task automatic test_key_change_mid_message();
    cfg_write(rc4ksc_pkg::CFG_KEY_LENGTH, rc4ksc_pkg::CFG_DATA_W'(5'd5));
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    cfg_write(rc4ksc_pkg::CFG_KEY_LOW, 64'hDEAD_BEEF_0BAD_F00D);
    cfg_write(rc4ksc_pkg::CFG_KEY_LENGTH, rc4ksc_pkg::CFG_DATA_W'(5'd12));
    send_byte(8'h56, 1'b1);
    send_byte(8'h78, 1'b1);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering bytes, so the
  // output register fills and the block stalls its input. Afterwards the sender pauses
  // until every result is back.
  task automatic test_output_stall();
    int n;
    send_byte(8'hC3, 1'b0);
    settle();
    stall_cycles = 300;
    -> rx_hold_go;
    tx_burst = 1'b1;
    for (n = 0; n < 6; n++) begin
      send_byte(8'($urandom), n == 5);
    end
    tx_burst = 1'b0;
    settle();
  endtask

  // Mostly well-formed messages with random content and lengths, new keys between messages,
  // and now and then a key change in mid-message, an unused register write or a long stall.
  task automatic test_random_messages();
    int unsigned start, len, n, mid;
    logic [rc4ksc_pkg::CFG_DATA_W-1:0] len_word;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: len = 1;
        1: len = $urandom_range(40, 80);
        default: len = $urandom_range(2, 20);
      endcase
      mid = ($urandom_range(0, 9) == 0 && len > 2) ? len / 2 : 0;
      tx_burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 1) == 0) begin
          cfg_write(rc4ksc_pkg::CFG_KEY_LOW, rand_key_word());
        end
        if ($urandom_range(0, 1) == 0) begin
          cfg_write(rc4ksc_pkg::CFG_KEY_HIGH, rand_key_word());
        end
        len_word = {$urandom, $urandom};
        len_word[rc4ksc_pkg::KEY_LEN_W-1:0] = ($urandom_range(0, 7) == 0)
            ? rc4ksc_pkg::KEY_LEN_W'($urandom_range(0, 31))
            : rc4ksc_pkg::KEY_LEN_W'($urandom_range(1, 16));
        cfg_write(rc4ksc_pkg::CFG_KEY_LENGTH, len_word);
        if ($urandom_range(0, 7) == 0) begin
          cfg_write(CFG_UNUSED_IDX, {$urandom, $urandom});
        end
      end
      if ($urandom_range(0, 39) == 0) begin
        settle();
        stall_cycles = $urandom_range(100, 250);
        -> rx_hold_go;
      end
      for (n = 0; n < len; n++) begin
        if (mid != 0 && n == mid) begin
          cfg_write(rc4ksc_pkg::CFG_KEY_LOW, rand_key_word());
        end
        send_byte(8'($urandom), n == len - 1);
      end
    end
    tx_burst = 1'b0;
  endtask

  initial begin
    din_if.valid     = 1'b0;
    din_if.data_byte = '0;
    din_if.last_byte = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_default_key();
    test_key_lengths();
    test_ignored_index();
    test_key_change_mid_message();
    test_output_stall();
    test_random_messages();

    // Let the last results drain, then give any stray transaction time to show up.
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d bytes in %0d key schedules, %0d results checked.",
             items_sent, sched_count, items_back);
    $display("Made %0d register writes, including bad lengths and the unused index.",
             cfg_writes);
    if (errors == 0 && cipher_due.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
